/* rtl/gifw_pkg.sv */
`timescale 1ns / 1ps

package gifw_pkg;

   // Screen size limits; larger register values saturate to these.
   localparam int MAX_SCREEN_WIDTH  = 2048;
   localparam int MAX_SCREEN_HEIGHT = 2048;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_START = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_IMAGE_LEFT    = 3'd2,
      CSR_IMAGE_TOP     = 3'd3,
      CSR_IMAGE_WIDTH   = 3'd4,
      CSR_IMAGE_HEIGHT  = 3'd5,
      CSR_INTERLACED    = 3'd6,
      CSR_TRANSPARENT   = 3'd7
   } csr_idx_type;

   // Effective image geometry, derived from the config registers.
   typedef struct packed {
      logic        err;
      logic [11:0] sw;
      logic [15:0] width;
      logic [15:0] vis_width;
      logic [15:0] height;
   } geom_type;

   // Raster position handed from the cursor to the pixel path.
   typedef struct packed {
      logic [15:0] column;
      logic [11:0] image_row;
      logic        busy;
      logic        last;
   } cur_type;

endpackage

/* rtl/gifw_ram.sv */
`timescale 1ns / 1ps

module gifw_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gifw_cursor.sv */
`timescale 1ns / 1ps

module gifw_cursor
   import gifw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  geom_type geom,
   input  logic     interlaced,
   input  logic     restart,
   input  logic     advance,
   output cur_type  cur
);

   logic [15:0] column_ff,    column_in;
   logic [11:0] rows_done_ff, rows_done_in;
   logic [11:0] image_row_ff, image_row_in;
   logic [2:0]  pass_ff,      pass_in;

   logic [16:0] col_inc;
   logic [12:0] rows_inc;
   logic        row_end;

   assign col_inc  = {1'b0, column_ff} + 17'd1;
   assign rows_inc = {1'b0, rows_done_ff} + 13'd1;
   assign row_end  = col_inc[15:0] >= geom.width;

   // Next row and pass; at most four pass changes per row end.
   always_comb begin
      logic [12:0] y;
      logic [2:0]  p;
      y = 13'd0;
      p = pass_ff;
      if (!interlaced) begin
         y = {1'b0, image_row_ff} + 13'd1;
      end else begin
         unique case (pass_ff)
            3'd2:    y = {1'b0, image_row_ff} + 13'd4;
            3'd3:    y = {1'b0, image_row_ff} + 13'd2;
            default: y = {1'b0, image_row_ff} + 13'd8;
         endcase
         for (int k = 0; k < 4; k++) begin
            if ({3'b0, y} >= geom.height) begin
               unique case (p)
                  3'd0:    y = 13'd4;
                  3'd1:    y = 13'd2;
                  3'd2:    y = 13'd1;
                  default: y = 13'd0;
               endcase
               p = p + 3'd1;
            end
         end
      end

      column_in    = column_ff;
      rows_done_in = rows_done_ff;
      image_row_in = image_row_ff;
      pass_in      = pass_ff;
      priority if (restart) begin
         column_in    = '0;
         rows_done_in = '0;
         image_row_in = '0;
         pass_in      = '0;
      end else if (advance) begin
         if (row_end) begin
            column_in    = '0;
            rows_done_in = rows_inc[11:0];
            image_row_in = y[11:0];
            pass_in      = p;
         end else begin
            column_in = col_inc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         rows_done_ff <= '0;
         image_row_ff <= '0;
         pass_ff      <= '0;
      end else begin
         column_ff    <= column_in;
         rows_done_ff <= rows_done_in;
         image_row_ff <= image_row_in;
         pass_ff      <= pass_in;
      end
   end

   assign cur.column    = column_ff;
   assign cur.image_row = image_row_ff;
   assign cur.busy      = {4'b0, rows_done_ff} < geom.height;
   assign cur.last      = (col_inc >= {1'b0, geom.width}) &&
                          ({3'b0, rows_inc} >= geom.height);

endmodule

/* rtl/gif_index_to_canvas_writer_top.sv */
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | command, color_index, palette_rgb
// rsp     | out       | rsp_valid / rsp_ready  | write_enable, pixel_address, pixel_color,
//         |           |                        | image_done, placement_error
// csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One item per cycle unless rsp stalls or a csr write stales the geometry.
// Item fields and the palette RAM read register at the accept edge; the address
// multiply then feeds the output register, which loads when stage 1 moves on.
// req_ready drops for one cycle after each csr write while the geometry register reloads.
// Reset is synchronous; the palette is not cleared, counters and config are.
// A stalled rsp holds its register; an item in the middle stage then holds and req_ready falls.

module gif_index_to_canvas_writer_top
   import gifw_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_color_index,
   input  logic [23:0] req_palette_rgb,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_enable,
   output logic [21:0] rsp_pixel_address,
   output logic [31:0] rsp_pixel_color,
   output logic        rsp_image_done,
   output logic        rsp_placement_error,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int         PAW       = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

   // ---------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------
   logic [11:0] scr_w_ff, scr_h_ff;
   logic [15:0] left_ff, top_ff, img_w_ff, img_h_ff;
   logic        interlaced_ff;
   logic [8:0]  transp_ff;
   logic        csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff      <= 12'd1;
         scr_h_ff      <= 12'd1;
         left_ff       <= '0;
         top_ff        <= '0;
         img_w_ff      <= '0;
         img_h_ff      <= '0;
         interlaced_ff <= 1'b0;
         transp_ff     <= 9'h1ff;
      end else if (csr_wr) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SCREEN_WIDTH:  scr_w_ff      <= csr_data[11:0];
            CSR_SCREEN_HEIGHT: scr_h_ff      <= csr_data[11:0];
            CSR_IMAGE_LEFT:    left_ff       <= csr_data;
            CSR_IMAGE_TOP:     top_ff        <= csr_data;
            CSR_IMAGE_WIDTH:   img_w_ff      <= csr_data;
            CSR_IMAGE_HEIGHT:  img_h_ff      <= csr_data;
            CSR_INTERLACED:    interlaced_ff <= csr_data[0];
            CSR_TRANSPARENT:   transp_ff     <= csr_data[8:0];
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Geometry, registered; stale for one cycle after any csr write
   // ---------------------------------------------------------------
   geom_type geom_ff, geom_in;
   logic     geom_stale_ff;

   always_comb begin
      logic [15:0] sw, sh, width, height, vis;
      logic        err;
      sw = ({4'b0, scr_w_ff} > 16'(MAX_SCREEN_WIDTH))  ? 16'(MAX_SCREEN_WIDTH)
                                                        : {4'b0, scr_w_ff};
      sh = ({4'b0, scr_h_ff} > 16'(MAX_SCREEN_HEIGHT)) ? 16'(MAX_SCREEN_HEIGHT)
                                                        : {4'b0, scr_h_ff};
      err    = (left_ff >= sw) || (top_ff >= sh);
      width  = (img_w_ff == 16'd0 || img_w_ff > sw) ? sw : img_w_ff;
      height = (img_h_ff == 16'd0 || img_h_ff > sh) ? sh : img_h_ff;
      vis    = width;
      if (!err && ({1'b0, left_ff} + {1'b0, width} > {1'b0, sw})) begin
         vis = sw - left_ff;
      end
      if (!err && ({1'b0, top_ff} + {1'b0, height} > {1'b0, sh})) begin
         height = sh - top_ff;
      end
      geom_in.err       = err;
      geom_in.sw        = sw[11:0];
      geom_in.width     = width;
      geom_in.vis_width = vis;
      geom_in.height    = height;
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
      if (reset) begin
         geom_stale_ff <= 1'b1;
      end else begin
         geom_stale_ff <= csr_wr;
      end
   end

   // ---------------------------------------------------------------
   // Handshake and pipeline control
   // ---------------------------------------------------------------
   logic    s1_valid_ff;
   logic    rsp_valid_ff;
   logic    out_free;
   logic    s1_move;
   logic    req_take;
   cmd_type cmd;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !geom_stale_ff && (!s1_valid_ff || out_free);
   assign req_take  = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);

   // ---------------------------------------------------------------
   // Stage 0: cursor update, palette access, write decision
   // ---------------------------------------------------------------
   cur_type cur;
   logic    is_pixel, pix_go, transparent, we0, pal_ok, restart;

   assign pal_ok      = {1'b0, req_color_index} < PAL_LIMIT;
   assign is_pixel    = (cmd == CMD_PIXEL) && !geom_ff.err && cur.busy;
   assign pix_go      = req_take && is_pixel;
   assign restart     = req_take && (cmd == CMD_START);
   assign transparent = !transp_ff[8] && (transp_ff[7:0] == req_color_index);
   assign we0         = is_pixel && (cur.column < geom_ff.vis_width) && !transparent;

   gifw_cursor u_cursor (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom_ff),
      .interlaced (interlaced_ff),
      .restart    (restart),
      .advance    (pix_go),
      .cur        (cur)
   );

   logic [23:0] pal_rd_data;

   // A load item also reads, but its read data is unused, so write-then-read ordering is enough.
   gifw_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (req_take && (cmd == CMD_LOAD) && pal_ok),
      .wr_addr (req_color_index[PAW-1:0]),
      .wr_data (req_palette_rgb),
      .rd_en   (req_take),
      .rd_addr (req_color_index[PAW-1:0]),
      .rd_data (pal_rd_data)
   );

   // ---------------------------------------------------------------
   // Stage 1: address multiply, palette data arrives
   // ---------------------------------------------------------------
   logic        s1_we_ff, s1_done_ff, s1_err_ff, s1_pal_ok_ff;
   logic [16:0] s1_row_ff, s1_col_ff;
   logic [11:0] s1_sw_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_we_ff     <= we0;
         s1_done_ff   <= is_pixel && cur.last;
         s1_err_ff    <= geom_ff.err;
         s1_pal_ok_ff <= pal_ok;
         s1_row_ff    <= {1'b0, top_ff} + {5'b0, cur.image_row};
         s1_col_ff    <= {1'b0, left_ff} + {1'b0, cur.column};
         s1_sw_ff     <= geom_ff.sw;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   logic [28:0] row_base;
   logic [21:0] addr1;
   logic [31:0] color1;

   assign row_base = s1_row_ff * s1_sw_ff;
   assign addr1    = row_base[21:0] + {5'b0, s1_col_ff};
   assign color1   = {ALPHA_OPAQUE, s1_pal_ok_ff ? pal_rd_data : 24'h0};

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic        rsp_we_ff, rsp_done_ff, rsp_err_ff;
   logic [21:0] rsp_addr_ff;
   logic [31:0] rsp_color_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_we_ff    <= s1_we_ff;
         rsp_addr_ff  <= s1_we_ff ? addr1 : 22'h0;
         rsp_color_ff <= s1_we_ff ? color1 : 32'h0;
         rsp_done_ff  <= s1_done_ff;
         rsp_err_ff   <= s1_err_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_write_enable    = rsp_we_ff;
   assign rsp_pixel_address   = rsp_addr_ff;
   assign rsp_pixel_color     = rsp_color_ff;
   assign rsp_image_done      = rsp_done_ff;
   assign rsp_placement_error = rsp_err_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_we_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> !rsp_placement_error)
      else $error("write issued for misplaced image");

   a_suppressed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_pixel_address == 22'h0 &&
                                         rsp_pixel_color == 32'h0)
      else $error("suppressed write carries data");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_row_ff) &&
                                   $stable(pal_rd_data))
      else $error("stage 1 item lost under stall");

   a_no_take_stale: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> !req_take)
      else $error("item taken with stale geometry");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> rsp_pixel_color[31:24] == ALPHA_OPAQUE)
      else $error("written pixel not opaque");

endmodule
